@@ src/ssba_pkg.sv @@
// ============================================================================
// ssba_pkg - shared types and constants of the spike suppressing averager
// Sizes of the delay line, window and block counters, pointer helpers,
// the order clamp and the release tag passed from line to accumulator.
// ============================================================================
`default_nettype none

package ssba_pkg;

    // sample and spike detection
    localparam int SAMPLE_WIDTH      = 32;
    localparam int SPIKE_PERIOD_LOG2 = 20;
    localparam int SPIKE_WINDOW      = 16;
    localparam int SPIKE_RATIO       = 10;
    localparam int RATIO_W           = $clog2(SPIKE_RATIO);
    localparam int AFTER_W           = $clog2(SPIKE_WINDOW + 1);

    // delay line
    localparam int LINE_DEPTH = SPIKE_WINDOW + 1;
    localparam int PTR_W      = $clog2(LINE_DEPTH);
    localparam int CNT_W      = $clog2(LINE_DEPTH + 1);

    // block averaging
    localparam int MAX_ORDER   = 20;
    localparam int ORDER_W     = 5;
    localparam int ORDER_RESET = 1;

    typedef logic [PTR_W-1:0]   t_ptr;
    typedef logic [CNT_W-1:0]   t_cnt;
    typedef logic [ORDER_W-1:0] t_order;

    typedef enum logic {
        LS_RUN,
        LS_DRAIN
    } t_line_state;

    // tag that travels with a sample released from the delay line
    typedef struct packed {
        logic valid;       // release data present
        logic is_cand;     // this sample is the spike candidate
        logic stream_end;  // final release of the stream
        t_cnt rem;         // releases still to come for the same item
    } t_rel_tag;

    // delay line status seen by the top level
    typedef struct packed {
        logic full;        // line holds LINE_DEPTH samples
        logic drain;       // flushing after end of data
        logic rel_free;    // release register can take a sample
    } t_line_stat;

    // advance a circular pointer
    function automatic t_ptr ptr_inc(input t_ptr p);
        t_ptr q;
        if (p == t_ptr'(LINE_DEPTH - 1)) begin
            q = '0;
        end else begin
            q = p + t_ptr'(1);
        end
        return q;
    endfunction

    // map a written order into 1..MAX_ORDER
    function automatic t_order clamp_order(input t_order v);
        t_order q;
        if (v == '0) begin
            q = t_order'(1);
        end else if (v > t_order'(MAX_ORDER)) begin
            q = t_order'(MAX_ORDER);
        end else begin
            q = v;
        end
        return q;
    endfunction

endpackage

`default_nettype wire

@@ src/ssba_detect.sv @@
// ============================================================================
// ssba_detect - spike candidate tracking
// Keeps the period position, a running maximum over the window before each
// candidate and the maximum of the samples after it. Decides the candidate
// in a two stage pipeline: pick the larger peak, then compare against the
// ratio times that peak.
// ============================================================================
`default_nettype none

module ssba_detect #(
    parameter int SAMPLE_WIDTH = ssba_pkg::SAMPLE_WIDTH
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_acc,
    input  wire signed [SAMPLE_WIDTH-1:0]  i_sample,
    input  wire                            i_eod,
    output logic                           o_cand_now,
    output logic                           o_spike,
    output logic signed [SAMPLE_WIDTH-1:0] o_big
);

    localparam int P  = ssba_pkg::SPIKE_PERIOD_LOG2;
    localparam int AW = ssba_pkg::AFTER_W;
    localparam int RW = SAMPLE_WIDTH + ssba_pkg::RATIO_W;
    // first period position inside the window before a candidate
    localparam logic [P-1:0] RUN_START = ~P'(ssba_pkg::SPIKE_WINDOW - 1);

    logic [P-1:0]                   r_pos;
    logic                           r_past;
    logic signed [SAMPLE_WIDTH-1:0] r_run;
    logic signed [SAMPLE_WIDTH-1:0] r_below;
    logic signed [SAMPLE_WIDTH-1:0] r_above;
    logic [AW-1:0]                  r_after;
    logic                           r_pend;
    logic signed [SAMPLE_WIDTH-1:0] r_cand_val;
    logic                           r_rs_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_rs_big;
    logic signed [SAMPLE_WIDTH-1:0] r_rs_cand;
    logic                           r_spike;
    logic signed [SAMPLE_WIDTH-1:0] r_big;

    logic [P-1:0]                   n_pos;
    logic                           n_pend;
    logic [AW-1:0]                  n_after;
    logic signed [SAMPLE_WIDTH-1:0] n_above;
    logic signed [SAMPLE_WIDTH-1:0] n_below;
    logic signed [SAMPLE_WIDTH-1:0] n_cand_val;
    logic signed [SAMPLE_WIDTH-1:0] above_new;
    logic [AW-1:0]                  after_new;
    logic                           resolve;
    logic signed [SAMPLE_WIDTH-1:0] big;
    logic signed [RW-1:0]           ten_big;
    logic signed [RW-1:0]           cand_ext;

    assign o_cand_now = r_past && (r_pos == '0);
    assign n_pos      = r_pos + P'(1);
    assign above_new  = ((r_after == '0) || (i_sample > r_above)) ? i_sample : r_above;
    assign after_new  = r_after + AW'(1);

    // open, extend or close the candidate window
    always_comb begin
        n_pend     = r_pend;
        n_after    = r_after;
        n_above    = r_above;
        n_below    = r_below;
        n_cand_val = r_cand_val;
        resolve    = 1'b0;
        if (o_cand_now) begin
            n_pend     = 1'b1;
            n_after    = '0;
            n_below    = r_run;
            n_cand_val = i_sample;
        end else if (r_pend) begin
            n_above = above_new;
            n_after = after_new;
            if (after_new == AW'(ssba_pkg::SPIKE_WINDOW)) begin
                resolve = 1'b1;
            end
        end
        if (i_eod && n_pend) begin
            resolve = 1'b1;
        end
        if (resolve) begin
            n_pend = 1'b0;
        end
        big = ((n_after != '0) && (n_above > n_below)) ? n_above : n_below;
    end

    // track window state per accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_past     <= 1'b0;
            r_pend     <= 1'b0;
            r_after    <= '0;
            r_rs_valid <= 1'b0;
        end else begin
            r_rs_valid <= i_acc && resolve;
            if (i_acc) begin
                r_pend     <= n_pend;
                r_after    <= n_after;
                r_above    <= n_above;
                r_below    <= n_below;
                r_cand_val <= n_cand_val;
                r_rs_big   <= big;
                r_rs_cand  <= n_cand_val;
                if (r_pos == RUN_START) begin
                    r_run <= i_sample;
                end else if ((r_pos > RUN_START) && (i_sample > r_run)) begin
                    r_run <= i_sample;
                end
                if (i_eod) begin
                    r_pos   <= '0;
                    r_past  <= 1'b0;
                    r_pend  <= 1'b0;
                    r_after <= '0;
                end else begin
                    r_pos <= n_pos;
                    if (n_pos == '0) begin
                        r_past <= 1'b1;
                    end
                end
            end
        end
    end

    // compare candidate with ratio times peak
    assign ten_big  = $signed({{ssba_pkg::RATIO_W{r_rs_big[SAMPLE_WIDTH-1]}}, r_rs_big})
                    * $signed({1'b0, ssba_pkg::RATIO_W'(ssba_pkg::SPIKE_RATIO)});
    assign cand_ext = $signed({{ssba_pkg::RATIO_W{r_rs_cand[SAMPLE_WIDTH-1]}}, r_rs_cand});

    always_ff @(posedge i_clk) begin
        if (r_rs_valid) begin
            r_spike <= cand_ext > ten_big;
            r_big   <= r_rs_big;
        end
    end

    assign o_spike = r_spike;
    assign o_big   = r_big;

endmodule

`default_nettype wire

@@ src/ssba_line.sv @@
// ============================================================================
// ssba_line - look-ahead delay line
// Circular buffer in a synchronous memory. A full line reads its oldest
// entry in the cycle a new sample overwrites it; end of data drains the rest
// one per cycle while rel_free is set; releases leave via a tagged register.
// ============================================================================
`default_nettype none

module ssba_line #(
    parameter int SAMPLE_WIDTH = ssba_pkg::SAMPLE_WIDTH
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_acc,
    input  wire [SAMPLE_WIDTH-1:0]        i_sample,
    input  wire                           i_eod,
    input  wire                           i_cand_now,
    input  wire                           i_rel_take,
    output ssba_pkg::t_line_stat          o_stat,
    output ssba_pkg::t_rel_tag            o_rel,
    output logic [SAMPLE_WIDTH-1:0]       o_data
);

    localparam int CW = ssba_pkg::CNT_W;

    logic [SAMPLE_WIDTH-1:0] r_mem [ssba_pkg::LINE_DEPTH];
    logic [SAMPLE_WIDTH-1:0] r_rd_data;

    ssba_pkg::t_line_state r_state;
    ssba_pkg::t_line_state n_state;
    ssba_pkg::t_ptr        r_head;
    ssba_pkg::t_ptr        r_tail;
    ssba_pkg::t_cnt        r_fill;
    ssba_pkg::t_cnt        r_left;
    ssba_pkg::t_ptr        r_cand_addr;
    logic                  r_cand_live;
    ssba_pkg::t_rel_tag    r_rel;

    logic               full;
    logic               rel_free;
    logic               rd_en;
    logic               drain_done;
    ssba_pkg::t_rel_tag rd_tag;

    assign full       = (r_fill == CW'(ssba_pkg::LINE_DEPTH));
    assign rel_free   = !r_rel.valid || i_rel_take;
    assign drain_done = (r_state == ssba_pkg::LS_DRAIN) && rel_free && (r_left == CW'(1));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ssba_pkg::LS_RUN: begin
                if (i_acc && i_eod) begin
                    n_state = ssba_pkg::LS_DRAIN;
                end
            end
            ssba_pkg::LS_DRAIN: begin
                if (drain_done) begin
                    n_state = ssba_pkg::LS_RUN;
                end
            end
        endcase
    end

    // read control and release tag
    always_comb begin
        rd_tag         = '0;
        rd_tag.valid   = 1'b1;
        rd_tag.is_cand = r_cand_live && (r_head == r_cand_addr);
        unique case (r_state)
            ssba_pkg::LS_RUN: begin
                rd_en      = i_acc && full;
                rd_tag.rem = i_eod ? CW'(ssba_pkg::LINE_DEPTH) : '0;
            end
            ssba_pkg::LS_DRAIN: begin
                rd_en             = rel_free;
                rd_tag.rem        = r_left - CW'(1);
                rd_tag.stream_end = (r_left == CW'(1));
            end
        endcase
    end

    // memory: write new sample, read oldest (old data on same entry)
    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_mem[r_tail] <= i_sample;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_head];
        end
    end

    // pointers, fill, drain count and release register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ssba_pkg::LS_RUN;
            r_head      <= '0;
            r_tail      <= '0;
            r_fill      <= '0;
            r_left      <= '0;
            r_cand_live <= 1'b0;
            r_rel       <= '0;
        end else begin
            r_state <= n_state;
            if (rd_en) begin
                r_rel  <= rd_tag;
                r_head <= ssba_pkg::ptr_inc(r_head);
                if (rd_tag.is_cand) begin
                    r_cand_live <= 1'b0;
                end
                if (r_state == ssba_pkg::LS_DRAIN) begin
                    r_left <= r_left - CW'(1);
                end
            end else if (i_rel_take) begin
                r_rel.valid <= 1'b0;
            end
            if (i_acc) begin
                r_tail <= ssba_pkg::ptr_inc(r_tail);
                if (!full) begin
                    r_fill <= r_fill + CW'(1);
                end
                if (i_cand_now) begin
                    r_cand_live <= 1'b1;
                    r_cand_addr <= r_tail;
                end
                if (i_eod) begin
                    r_left <= full ? CW'(ssba_pkg::LINE_DEPTH) : r_fill + CW'(1);
                end
            end
            if (drain_done) begin
                r_head      <= '0;
                r_tail      <= '0;
                r_fill      <= '0;
                r_cand_live <= 1'b0;
            end
        end
    end

    assign o_stat.full     = full;
    assign o_stat.drain    = (r_state == ssba_pkg::LS_DRAIN);
    assign o_stat.rel_free = rel_free;
    assign o_rel           = r_rel;
    assign o_data          = r_rd_data;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(ssba_pkg::LINE_DEPTH))
        else $error("delay line overfilled");

    a_drain_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        drain_done |=> (r_fill == '0) && (r_state == ssba_pkg::LS_RUN))
        else $error("line not cleared after drain");

    a_no_write_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_acc |-> (r_state == ssba_pkg::LS_RUN))
        else $error("item accepted while draining");
`endif

endmodule

`default_nettype wire

@@ src/ssba_accum.sv @@
// ============================================================================
// ssba_accum - block accumulator and output stage
// Substitutes the decided value for a spike, sums released samples exactly,
// hands each full block to a shift stage and holds the average in the
// output register until it is taken.
// ============================================================================
`default_nettype none

module ssba_accum #(
    parameter int SAMPLE_WIDTH = ssba_pkg::SAMPLE_WIDTH
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  ssba_pkg::t_rel_tag             i_rel,
    input  wire signed [SAMPLE_WIDTH-1:0]  i_data,
    input  wire                            i_spike,
    input  wire signed [SAMPLE_WIDTH-1:0]  i_big,
    input  ssba_pkg::t_order               i_order,
    input  wire                            i_clear,
    input  wire                            i_stall,
    output logic                           o_rel_take,
    output logic                           o_valid,
    output logic signed [SAMPLE_WIDTH-1:0] o_average,
    output logic                           o_last_result
);

    localparam int MO    = ssba_pkg::MAX_ORDER;
    localparam int SUM_W = SAMPLE_WIDTH + MO;

    logic signed [SUM_W-1:0]        r_sum;
    logic [MO-1:0]                  r_bfill;
    logic                           r_blk_valid;
    logic signed [SUM_W-1:0]        r_blk_sum;
    logic                           r_blk_last;
    logic                           r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_out_avg;
    logic                           r_out_last;

    logic signed [SAMPLE_WIDTH-1:0] value;
    logic signed [SUM_W-1:0]        sum_new;
    logic signed [SUM_W-1:0]        shifted;
    logic [MO-1:0]                  fill_mask;
    logic                           done;
    logic                           last;
    logic                           out_free;
    logic                           blk_free;
    logic                           take;

    assign value     = (i_rel.is_cand && i_spike) ? i_big : i_data;
    assign sum_new   = r_sum + $signed({{MO{value[SAMPLE_WIDTH-1]}}, value});
    assign fill_mask = ~({MO{1'b1}} << i_order);
    assign done      = (r_bfill == fill_mask);
    assign last      = ((i_rel.rem >> i_order) == '0);
    assign out_free  = !r_out_valid || !i_stall;
    assign blk_free  = !r_blk_valid || out_free;
    assign take      = i_rel.valid && (!done || blk_free);
    assign shifted   = r_blk_sum >>> i_order;

    // accumulate one released sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_bfill <= '0;
        end else if (i_clear) begin
            r_sum   <= '0;
            r_bfill <= '0;
        end else if (take) begin
            if (done || i_rel.stream_end) begin
                r_sum   <= '0;
                r_bfill <= '0;
            end else begin
                r_sum   <= sum_new;
                r_bfill <= r_bfill + MO'(1);
            end
        end
    end

    // hold finished block, then shift it into the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blk_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (take && done) begin
                r_blk_valid <= 1'b1;
                r_blk_sum   <= sum_new;
                r_blk_last  <= last;
            end else if (out_free) begin
                r_blk_valid <= 1'b0;
            end
            if (r_blk_valid && out_free) begin
                r_out_valid <= 1'b1;
                r_out_avg   <= shifted[SAMPLE_WIDTH-1:0];
                r_out_last  <= r_blk_last;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_rel_take    = take;
    assign o_valid       = r_out_valid;
    assign o_average     = r_out_avg;
    assign o_last_result = r_out_last;

`ifndef SYNTHESIS
    a_out_from_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_blk_valid))
        else $error("result without finished block");
`endif

endmodule

`default_nettype wire

@@ src/spike_suppress_block_average_core.sv @@
// ============================================================================
// spike_suppress_block_average_core - spike removal and boxcar decimation
// Replaces periodic spike candidates that exceed ten times their neighbor
// peak, then emits the floor average of each block of 2^order samples.
// ============================================================================
//
//  channel   direction  handshake                 payload
//  -------   ---------  ------------------------  ---------------------------------
//  input     in         i_valid / o_stall         i_sample, i_end_of_data
//  output    out        o_valid / i_stall         o_average, o_last_result
//  config    in         i_cfg_we                  i_cfg_wdata (decimation order)
//
//  One item per cycle while o_stall is low. A result passes the memory read,
//  block and output registers (memory read, accumulate, shift) once the item
//  that completes its block is released. An item with end of data is followed
//  by a drain of up to 17 delay line entries, one per cycle while the output
//  is not stalled, during which no item is accepted.
//  Output stall backs up through the shift and accumulate registers into the
//  delay line read; outside a drain, input stalls only when the line is full
//  and cannot release.
//  Reset is synchronous, active low; the delay line memory is not cleared.
//
`default_nettype none

module spike_suppress_block_average_core #(
    parameter int SAMPLE_WIDTH = ssba_pkg::SAMPLE_WIDTH
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_valid,
    output logic                             o_stall,
    input  wire signed [SAMPLE_WIDTH-1:0]    i_sample,
    input  wire                              i_end_of_data,
    output logic                             o_valid,
    input  wire                              i_stall,
    output logic signed [SAMPLE_WIDTH-1:0]   o_average,
    output logic                             o_last_result,
    input  wire                              i_cfg_we,
    input  wire [ssba_pkg::ORDER_W-1:0]      i_cfg_wdata
);

    ssba_pkg::t_order     r_order;
    ssba_pkg::t_line_stat line_stat;
    ssba_pkg::t_rel_tag   rel;

    logic                           acc;
    logic                           cand_now;
    logic                           spike;
    logic signed [SAMPLE_WIDTH-1:0] big;
    logic [SAMPLE_WIDTH-1:0]        rel_data;
    logic                           rel_take;

    // stall while draining, or when a full line cannot release
    assign o_stall = line_stat.drain || (line_stat.full && !line_stat.rel_free);
    assign acc     = i_valid && !o_stall;

    // decimation order register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= ssba_pkg::t_order'(ssba_pkg::ORDER_RESET);
        end else if (i_cfg_we) begin
            r_order <= ssba_pkg::clamp_order(i_cfg_wdata);
        end
    end

    ssba_detect #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_detect (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_acc      (acc),
        .i_sample   (i_sample),
        .i_eod      (i_end_of_data),
        .o_cand_now (cand_now),
        .o_spike    (spike),
        .o_big      (big)
    );

    ssba_line #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_line (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_acc      (acc),
        .i_sample   (i_sample),
        .i_eod      (i_end_of_data),
        .i_cand_now (cand_now),
        .i_rel_take (rel_take),
        .o_stat     (line_stat),
        .o_rel      (rel),
        .o_data     (rel_data)
    );

    ssba_accum #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_accum (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rel         (rel),
        .i_data        ($signed(rel_data)),
        .i_spike       (spike),
        .i_big         (big),
        .i_order       (r_order),
        .i_clear       (i_cfg_we),
        .i_stall       (i_stall),
        .o_rel_take    (rel_take),
        .o_valid       (o_valid),
        .o_average     (o_average),
        .o_last_result (o_last_result)
    );

`ifndef SYNTHESIS
    a_order_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_order != '0) && (r_order <= ssba_pkg::t_order'(ssba_pkg::MAX_ORDER)))
        else $error("decimation order out of range");
`endif

endmodule

`default_nettype wire
